FILE: rtl/hpt_pkg.sv
// hpt_pkg: shared types, codes and defaults for the hashed page table.
// Used by every module under rtl/; depends on nothing.
`default_nettype none

package hpt_pkg;

    localparam int MAX_BUCKETS_DEF      = 64;
    localparam int SLOTS_PER_BUCKET_DEF = 8;
    localparam int NUM_TABLES_DEF       = 2;
    localparam int PAGE_BITS_DEF        = 20;
    localparam int FRAME_BITS_DEF       = 16;

    // bucket count register
    localparam int              CNT_W            = 7;
    localparam logic [CNT_W-1:0] BUCKET_COUNT_RST = 7'd64;

    // remainder unit retires this many dividend bits per cycle
    localparam int DIGIT_W = 4;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_NOP    = 2'd3
    } op_kind_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_EVAL,
        B_DONE
    } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/hpt_fifo.sv
// hpt_fifo: small register queue used between the front and back and on the result side.
// Depends on hpt_pkg for the default depth.
`default_nettype none

module hpt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = hpt_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CQ_W  = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CQ_W-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CQ_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/hpt_front.sv
// hpt_front: takes requests, hashes the page to a bucket row with a digit-serial
// remainder unit and hands the classified operation to the op queue. Uses hpt_pkg.
`default_nettype none

module hpt_front #(
    parameter int MAX_BUCKETS = hpt_pkg::MAX_BUCKETS_DEF,
    parameter int NUM_TABLES  = hpt_pkg::NUM_TABLES_DEF,
    parameter int PAGE_BITS   = hpt_pkg::PAGE_BITS_DEF,
    parameter int FRAME_BITS  = hpt_pkg::FRAME_BITS_DEF,
    parameter int ADDR_W      = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [hpt_pkg::CNT_W-1:0]   bucket_count,
    input  logic                        accept,
    input  logic [1:0]                  kind,
    input  logic                        table_select,
    input  logic [PAGE_BITS-1:0]        page_number,
    input  logic [FRAME_BITS-1:0]       frame_number,
    input  logic                        modified_in,
    input  logic                        referenced_in,
    output logic                        busy,
    output logic                        op_push,
    input  logic                        op_full,
    output hpt_pkg::op_kind_t           op_kind,
    output logic [ADDR_W-1:0]           op_addr,
    output logic [PAGE_BITS-1:0]        op_page,
    output logic [FRAME_BITS-1:0]       op_frame,
    output logic                        op_mod,
    output logic                        op_ref
);

    import hpt_pkg::*;

    localparam int DIV_STEPS = (PAGE_BITS + DIGIT_W - 1) / DIGIT_W;
    localparam int DIV_W     = DIV_STEPS * DIGIT_W;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    front_state_t          state_reg, state_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [DIV_W-1:0]      div_reg, div_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic [CNT_W-1:0]      divisor_reg, divisor_next;
    logic                  tbl_reg, tbl_next;
    op_kind_t              kind_reg, kind_next;
    logic [PAGE_BITS-1:0]  page_reg, page_next;
    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic                  mod_reg, mod_next;
    logic                  ref_reg, ref_next;
    logic [CNT_W-1:0]      eff_count;
    logic [CNT_W-1:0]      rem_step;

    // zero means one bucket, anything above the table size saturates
    always_comb
    begin
        if (bucket_count == '0)
        begin
            eff_count = CNT_W'(1);
        end
        else if (32'(bucket_count) > MAX_BUCKETS)
        begin
            eff_count = CNT_W'(MAX_BUCKETS);
        end
        else
        begin
            eff_count = bucket_count;
        end
    end

    // restoring remainder, DIGIT_W dividend bits per cycle
    always_comb
    begin
        logic [CNT_W:0] t;
        rem_step = rem_reg;
        for (int j = 0; j < DIGIT_W; j++)
        begin
            t = {rem_step, div_reg[DIV_W-1-j]};
            if (t >= {1'b0, divisor_reg})
            begin
                t = t - {1'b0, divisor_reg};
            end
            rem_step = t[CNT_W-1:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!op_full)
                begin
                    state_next = accept ? F_DIV : F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy    = 1'b1;
        op_push = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                busy = 1'b0;
            end
            F_DIV:
            begin
                busy = 1'b1;
            end
            F_PUSH:
            begin
                op_push = !op_full;
                busy    = op_full;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        step_next    = step_reg;
        div_next     = div_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        tbl_next     = tbl_reg;
        kind_next    = kind_reg;
        page_next    = page_reg;
        frame_next   = frame_reg;
        mod_next     = mod_reg;
        ref_next     = ref_reg;
        if (accept)
        begin
            step_next    = '0;
            div_next     = DIV_W'(page_number);
            rem_next     = '0;
            divisor_next = eff_count;
            tbl_next     = (NUM_TABLES > 1) ? table_select : 1'b0;
            kind_next    = op_kind_t'(kind);
            page_next    = page_number;
            frame_next   = frame_number;
            mod_next     = modified_in;
            ref_next     = referenced_in;
        end
        else if (state_reg == F_DIV)
        begin
            step_next = step_reg + 1'b1;
            div_next  = div_reg << DIGIT_W;
            rem_next  = rem_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg     <= div_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        tbl_reg     <= tbl_next;
        kind_reg    <= kind_next;
        page_reg    <= page_next;
        frame_reg   <= frame_next;
        mod_reg     <= mod_next;
        ref_reg     <= ref_next;
    end

    assign op_addr  = ADDR_W'(32'(tbl_reg) * MAX_BUCKETS + 32'(rem_reg));
    assign op_kind  = kind_reg;
    assign op_page  = page_reg;
    assign op_frame = frame_reg;
    assign op_mod   = mod_reg;
    assign op_ref   = ref_reg;

endmodule

`default_nettype wire

FILE: rtl/hpt_back.sv
// hpt_back: owns the bucket row memory and fill counts; reads a row, matches all
// slots, writes the appended or compacted row back and emits the result. Uses hpt_pkg.
`default_nettype none

module hpt_back #(
    parameter int MAX_BUCKETS      = hpt_pkg::MAX_BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = hpt_pkg::SLOTS_PER_BUCKET_DEF,
    parameter int NUM_TABLES       = hpt_pkg::NUM_TABLES_DEF,
    parameter int PAGE_BITS        = hpt_pkg::PAGE_BITS_DEF,
    parameter int FRAME_BITS       = hpt_pkg::FRAME_BITS_DEF,
    parameter int ADDR_W           = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  op_valid,
    output logic                  op_pop,
    input  hpt_pkg::op_kind_t     op_kind,
    input  logic [ADDR_W-1:0]     op_addr,
    input  logic [PAGE_BITS-1:0]  op_page,
    input  logic [FRAME_BITS-1:0] op_frame,
    input  logic                  op_mod,
    input  logic                  op_ref,
    output logic                  clearing,
    output logic                  res_push,
    input  logic                  res_full,
    output hpt_pkg::status_t      res_status,
    output logic [FRAME_BITS-1:0] res_frame,
    output logic                  res_mod,
    output logic                  res_ref
);

    import hpt_pkg::*;

    localparam int SLOTS  = SLOTS_PER_BUCKET;
    localparam int ROWS   = NUM_TABLES * MAX_BUCKETS;
    localparam int ENT_W  = PAGE_BITS + FRAME_BITS + 2;
    localparam int ROW_W  = SLOTS * ENT_W;
    localparam int FILL_W = $clog2(SLOTS + 1);
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // entry layout: {page, frame, modified, referenced}
    logic [ROW_W-1:0]      slot_mem [ROWS];
    logic [FILL_W-1:0]     fill_mem [ROWS];

    back_state_t           state_reg, state_next;
    logic [ADDR_W-1:0]     clr_addr_reg, clr_addr_next;
    op_kind_t              kind_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic [PAGE_BITS-1:0]  page_reg;
    logic [FRAME_BITS-1:0] frame_reg;
    logic                  mod_reg;
    logic                  ref_reg;
    logic [ROW_W-1:0]      rd_row_reg;
    logic [FILL_W-1:0]     rd_fill_reg;
    logic                  hit_reg, hit_next;
    logic [SLOT_W-1:0]     idx_reg, idx_next;

    logic [ENT_W-1:0]      slot_ent [SLOTS];
    logic [SLOTS-1:0]      match;
    logic [ENT_W-1:0]      new_ent;
    logic [ENT_W-1:0]      sel_ent;
    logic [ROW_W-1:0]      shifted_row;
    logic [ROW_W-1:0]      ins_row;
    logic [ROW_W-1:0]      del_row;
    logic                  row_full;
    logic                  rd_en;
    logic                  row_we;
    logic                  fill_we;
    logic [ROW_W-1:0]      row_wdata;
    logic [FILL_W-1:0]     fill_wdata;
    logic [ADDR_W-1:0]     wr_addr;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_ent[i] = rd_row_reg[i*ENT_W +: ENT_W];
            match[i]    = (FILL_W'(i) < rd_fill_reg) &&
                          (slot_ent[i][ENT_W-1 -: PAGE_BITS] == page_reg);
        end
    end

    // first match wins
    always_comb
    begin
        hit_next = |match;
        idx_next = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                idx_next = SLOT_W'(i);
            end
        end
    end

    assign new_ent     = {page_reg, frame_reg, mod_reg, ref_reg};
    assign sel_ent     = slot_ent[idx_reg];
    assign shifted_row = rd_row_reg >> ENT_W;
    assign row_full    = (rd_fill_reg >= FILL_W'(SLOTS));

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            ins_row[i*ENT_W +: ENT_W] = (FILL_W'(i) == rd_fill_reg) ? new_ent : slot_ent[i];
            del_row[i*ENT_W +: ENT_W] = (SLOT_W'(i) >= idx_reg) ?
                                        shifted_row[i*ENT_W +: ENT_W] : slot_ent[i];
        end
    end

    // next state
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        unique case (state_reg)
            B_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(ROWS - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (op_valid)
                begin
                    state_next = B_EVAL;
                end
            end
            B_EVAL:
            begin
                state_next = B_DONE;
            end
            B_DONE:
            begin
                if (!res_full)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        op_pop     = 1'b0;
        rd_en      = 1'b0;
        row_we     = 1'b0;
        fill_we    = 1'b0;
        row_wdata  = ins_row;
        fill_wdata = '0;
        res_push   = 1'b0;
        res_status = ST_ABSENT;
        res_frame  = '0;
        res_mod    = 1'b0;
        res_ref    = 1'b0;
        clearing   = 1'b0;
        unique case (state_reg)
            B_CLEAR:
            begin
                clearing = 1'b1;
                fill_we  = 1'b1;
            end
            B_IDLE:
            begin
                op_pop = op_valid;
                rd_en  = op_valid;
            end
            B_EVAL:
            begin
                rd_en = 1'b0;
            end
            B_DONE:
            begin
                res_push = !res_full;
                case (kind_reg)
                    OP_LOOKUP:
                    begin
                        if (hit_reg)
                        begin
                            res_status = ST_OK;
                            res_frame  = sel_ent[FRAME_BITS+1:2];
                            res_mod    = sel_ent[1];
                            res_ref    = sel_ent[0];
                        end
                    end
                    OP_INSERT:
                    begin
                        if (row_full)
                        begin
                            res_status = ST_FULL;
                        end
                        else
                        begin
                            res_status = ST_OK;
                            row_we     = !res_full;
                            fill_we    = !res_full;
                            fill_wdata = rd_fill_reg + 1'b1;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (hit_reg)
                        begin
                            res_status = ST_OK;
                            row_we     = !res_full;
                            fill_we    = !res_full;
                            row_wdata  = del_row;
                            fill_wdata = rd_fill_reg - 1'b1;
                        end
                    end
                    default:
                    begin
                        res_status = ST_ABSENT;
                    end
                endcase
            end
            default:
            begin
                clearing = 1'b0;
            end
        endcase
    end

    assign wr_addr = (state_reg == B_CLEAR) ? clr_addr_reg : addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op_pop)
        begin
            kind_reg  <= op_kind;
            addr_reg  <= op_addr;
            page_reg  <= op_page;
            frame_reg <= op_frame;
            mod_reg   <= op_mod;
            ref_reg   <= op_ref;
        end
        if (state_reg == B_EVAL)
        begin
            hit_reg <= hit_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            slot_mem[wr_addr] <= row_wdata;
        end
        if (rd_en)
        begin
            rd_row_reg <= slot_mem[op_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem[wr_addr] <= fill_wdata;
        end
        if (rd_en)
        begin
            rd_fill_reg <= fill_mem[op_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/hashed_page_table.sv
// Two hashed page tables with bounded, insertion-ordered bucket chains. A request
// is hashed by the front (page modulo bucket count, four page bits per cycle), and
// the front takes no new request until it has handed the last one to the op queue.
// The back takes one operation at a time through the bucket row memory (read row,
// match all slots, write back and post the result, held while the result queue is
// full); a two-entry op queue and a two-entry result queue sit between the parts
// and the ports. After reset a clearing pass zeroes the fill counts of all rows,
// NUM_TABLES*MAX_BUCKETS (128 by default), during which full stays high; the
// bucket count register can be written anytime the block is idle.
`default_nettype none

module hashed_page_table #(
    parameter int MAX_BUCKETS      = hpt_pkg::MAX_BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = hpt_pkg::SLOTS_PER_BUCKET_DEF,
    parameter int NUM_TABLES       = hpt_pkg::NUM_TABLES_DEF,
    parameter int PAGE_BITS        = hpt_pkg::PAGE_BITS_DEF,
    parameter int FRAME_BITS       = hpt_pkg::FRAME_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      bucket_count_we,
    input  logic [hpt_pkg::CNT_W-1:0] bucket_count,
    input  logic                      push,
    output logic                      full,
    input  logic [1:0]                kind,
    input  logic                      table_select,
    input  logic [PAGE_BITS-1:0]      page_number,
    input  logic [FRAME_BITS-1:0]     frame_number,
    input  logic                      modified_in,
    input  logic                      referenced_in,
    output logic                      empty,
    input  logic                      pop,
    output logic [1:0]                status,
    output logic [FRAME_BITS-1:0]     frame_out,
    output logic                      modified_out,
    output logic                      referenced_out
);

    import hpt_pkg::*;

    localparam int ROWS   = NUM_TABLES * MAX_BUCKETS;
    localparam int ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int OP_W   = 2 + ADDR_W + PAGE_BITS + FRAME_BITS + 2;
    localparam int RES_W  = 2 + FRAME_BITS + 2;

    logic [CNT_W-1:0]      bucket_count_reg;
    logic                  accept;
    logic                  front_busy;
    logic                  clearing;

    logic                  op_push, op_full, op_empty, op_pop;
    op_kind_t              f_kind;
    logic [ADDR_W-1:0]     f_addr;
    logic [PAGE_BITS-1:0]  f_page;
    logic [FRAME_BITS-1:0] f_frame;
    logic                  f_mod, f_ref;
    logic [OP_W-1:0]       op_wdata, op_rdata;

    logic                  res_push, res_full;
    status_t               r_status;
    logic [FRAME_BITS-1:0] r_frame;
    logic                  r_mod, r_ref;
    logic [RES_W-1:0]      res_wdata, res_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= BUCKET_COUNT_RST;
        end
        else if (bucket_count_we)
        begin
            bucket_count_reg <= bucket_count;
        end
    end

    assign full   = front_busy || clearing;
    assign accept = push && !full;

    hpt_front #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .NUM_TABLES  (NUM_TABLES),
        .PAGE_BITS   (PAGE_BITS),
        .FRAME_BITS  (FRAME_BITS),
        .ADDR_W      (ADDR_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .bucket_count  (bucket_count_reg),
        .accept        (accept),
        .kind          (kind),
        .table_select  (table_select),
        .page_number   (page_number),
        .frame_number  (frame_number),
        .modified_in   (modified_in),
        .referenced_in (referenced_in),
        .busy          (front_busy),
        .op_push       (op_push),
        .op_full       (op_full),
        .op_kind       (f_kind),
        .op_addr       (f_addr),
        .op_page       (f_page),
        .op_frame      (f_frame),
        .op_mod        (f_mod),
        .op_ref        (f_ref)
    );

    assign op_wdata = {f_kind, f_addr, f_page, f_frame, f_mod, f_ref};

    hpt_fifo #(
        .WIDTH (OP_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_op_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (op_push),
        .wdata (op_wdata),
        .pop   (op_pop),
        .rdata (op_rdata),
        .full  (op_full),
        .empty (op_empty)
    );

    hpt_back #(
        .MAX_BUCKETS      (MAX_BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
        .NUM_TABLES       (NUM_TABLES),
        .PAGE_BITS        (PAGE_BITS),
        .FRAME_BITS       (FRAME_BITS),
        .ADDR_W           (ADDR_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (!op_empty),
        .op_pop     (op_pop),
        .op_kind    (op_kind_t'(op_rdata[OP_W-1 -: 2])),
        .op_addr    (op_rdata[OP_W-3 -: ADDR_W]),
        .op_page    (op_rdata[FRAME_BITS+2 +: PAGE_BITS]),
        .op_frame   (op_rdata[2 +: FRAME_BITS]),
        .op_mod     (op_rdata[1]),
        .op_ref     (op_rdata[0]),
        .clearing   (clearing),
        .res_push   (res_push),
        .res_full   (res_full),
        .res_status (r_status),
        .res_frame  (r_frame),
        .res_mod    (r_mod),
        .res_ref    (r_ref)
    );

    assign res_wdata = {r_status, r_frame, r_mod, r_ref};

    hpt_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .pop   (pop),
        .rdata (res_rdata),
        .full  (res_full),
        .empty (empty)
    );

    assign status         = res_rdata[RES_W-1 -: 2];
    assign frame_out      = res_rdata[2 +: FRAME_BITS];
    assign modified_out   = res_rdata[1];
    assign referenced_out = res_rdata[0];

endmodule

`default_nettype wire

FILE: rtl/hpt_checker.sv
// hpt_port_checker: port-level assertions for hashed_page_table, bound to the top level.
// Depends on hpt_pkg for status codes and defaults.
`default_nettype none

module hpt_port_checker #(
    parameter int FRAME_BITS = hpt_pkg::FRAME_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  full,
    input  logic                  empty,
    input  logic                  pop,
    input  logic [1:0]            status,
    input  logic [FRAME_BITS-1:0] frame_out,
    input  logic                  modified_out,
    input  logic                  referenced_out
);

    import hpt_pkg::*;

    // the front is busy while it hashes, so an accepted request always blocks the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full |=> full)
        else $error("request input not blocked while hashing");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status == ST_OK || status == ST_ABSENT || status == ST_FULL))
        else $error("unknown status code");

    // only a lookup hit carries entry data
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && status != ST_OK |-> frame_out == '0 && !modified_out && !referenced_out)
        else $error("result data on a miss or refusal");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(status) && $stable(frame_out))
        else $error("waiting result changed before pop");

endmodule

bind hashed_page_table hpt_port_checker #(
    .FRAME_BITS (FRAME_BITS)
) u_hpt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .status         (status),
    .frame_out      (frame_out),
    .modified_out   (modified_out),
    .referenced_out (referenced_out)
);

`default_nettype wire
